// ===== rtl/f4alu_pkg.sv =====
`timescale 1ns / 1ps

package f4alu_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   localparam logic [31:0] CANON_NAN    = 32'h7FC0_0000;
   localparam logic [30:0] THRESH_RESET = 31'h3586_37BD;
   localparam int          DIV_STEPS    = 26;
   localparam logic [2:0]  ADDR_THRESH  = 3'd0;

   // front end: unpacked operands, swapped by magnitude for add/sub
   typedef struct packed {
      op_type      op;
      logic        xs;
      logic        ys;
      logic [7:0]  xe;
      logic [7:0]  ye;
      logic [23:0] xm;
      logic [23:0] ym;
      logic        spec;
      logic [31:0] spec_bits;
      logic        err;
   } unp_type;

   // aligned / multiplied / prenormalized operands
   typedef struct packed {
      op_type             op;
      logic               sgn;
      logic               ysgn;
      logic               sub;
      logic signed [11:0] ex;
      logic [47:0]        a48;
      logic [47:0]        b48;
      logic               spec;
      logic [31:0]        spec_bits;
      logic               err;
   } opr_type;

   // common form: value = man / 2^47 * 2^(ex - 127), sticky folded into bit 0
   typedef struct packed {
      op_type             op;
      logic               sgn;
      logic signed [11:0] ex;
      logic [47:0]        man;
      logic               spec;
      logic [31:0]        spec_bits;
      logic               err;
   } pl_type;

   typedef struct packed {
      logic [24:0] rem;
      logic [23:0] dvs;
      logic [25:0] quo;
   } dv_type;

   typedef struct packed {
      pl_type     pl;
      logic       left;
      logic [5:0] amt;
   } nrm_type;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd24;
      hit = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (v[i] && !hit) begin
            n   = 5'(23 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       hit;
      n   = 6'd48;
      hit = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (v[i] && !hit) begin
            n   = 6'(47 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/float_four_op_alu.sv =====
`timescale 1ns / 1ps

// Single-precision add / subtract / multiply / divide, round to nearest even,
// subnormals kept, every NaN result given as 0x7FC00000. A divide whose
// divisor magnitude is below the csr threshold (byte address 0, reset 1e-6)
// returns +0 with rsp_tuser set. One operation is accepted per clock while req_tready
// is high; it drops while the skid entry is full. Every operation passes through the
// 26-stage radix-2 divider array. A two-entry output register/skid pair lets
// req_tready stay high while one result waits.
module float_four_op_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_bits
   output logic        rsp_tuser,   // [0] divide_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NS = f4alu_pkg::DIV_STEPS;

   logic [30:0] thresh_ff, thresh_in;
   logic        adv;

   logic                s1_valid_ff, s1_valid_in;
   f4alu_pkg::unp_type  s1_ff, s1_in;
   logic                s2_valid_ff, s2_valid_in;
   f4alu_pkg::opr_type  s2_ff, s2_in;
   logic                pv_ff [NS+1];
   logic                pv_in [NS+1];
   f4alu_pkg::pl_type   pl_ff [NS+1];
   f4alu_pkg::pl_type   pl_in [NS+1];
   f4alu_pkg::dv_type   dv_ff [NS+1];
   f4alu_pkg::dv_type   dv_in [NS+1];
   logic                n1_valid_ff, n1_valid_in;
   f4alu_pkg::nrm_type  n1_ff, n1_in;
   logic                n2_valid_ff, n2_valid_in;
   f4alu_pkg::pl_type   n2_ff, n2_in;

   logic        out_valid_ff, out_valid_in;
   logic [32:0] out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [32:0] skid_ff, skid_in;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == f4alu_pkg::ADDR_THRESH[2]) ? {1'b0, thresh_ff}
                                                                   : 32'd0;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && (csr_paddr[2] == f4alu_pkg::ADDR_THRESH[2])) begin
         thresh_in = csr_pwdata[30:0];
      end
   end

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // ---------------- stage 1: unpack, specials, threshold ----------------
   always_comb begin
      logic [31:0] a, b;
      logic        sa, sb, sbe, sx;
      logic [7:0]  eaf, ebf, ea, eb;
      logic [23:0] ma, mb;
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, th_nan, swap;
      f4alu_pkg::op_type op;
      a      = req_tdata[31:0];
      b      = req_tdata[63:32];
      op     = f4alu_pkg::op_type'(req_tuser);
      sa     = a[31];
      sb     = b[31];
      sbe    = sb ^ (op == f4alu_pkg::OP_SUB);
      sx     = sa ^ sb;
      eaf    = a[30:23];
      ebf    = b[30:23];
      nan_a  = (eaf == 8'hFF) && (a[22:0] != 23'd0);
      nan_b  = (ebf == 8'hFF) && (b[22:0] != 23'd0);
      inf_a  = (eaf == 8'hFF) && (a[22:0] == 23'd0);
      inf_b  = (ebf == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = (a[30:0] == 31'd0);
      zero_b = (b[30:0] == 31'd0);
      ea     = (eaf == 8'd0) ? 8'd1 : eaf;
      eb     = (ebf == 8'd0) ? 8'd1 : ebf;
      ma     = {eaf != 8'd0, a[22:0]};
      mb     = {ebf != 8'd0, b[22:0]};
      th_nan = (thresh_ff[30:23] == 8'hFF) && (thresh_ff[22:0] != 23'd0);
      swap   = {eb, mb} > {ea, ma};

      s1_in           = '0;
      s1_in.op        = op;
      s1_in.err       = (op == f4alu_pkg::OP_DIV) && !nan_b && !th_nan
                        && (b[30:0] < thresh_ff);
      case (op)
         f4alu_pkg::OP_ADD, f4alu_pkg::OP_SUB: begin
            s1_in.xs = swap ? sbe : sa;
            s1_in.xe = swap ? eb : ea;
            s1_in.xm = swap ? mb : ma;
            s1_in.ys = swap ? sa : sbe;
            s1_in.ye = swap ? ea : eb;
            s1_in.ym = swap ? ma : mb;
            if (nan_a || nan_b || (inf_a && inf_b && (sa != sbe))) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = f4alu_pkg::CANON_NAN;
            end else if (inf_a) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = {sa, 8'hFF, 23'd0};
            end else if (inf_b) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = {sbe, 8'hFF, 23'd0};
            end
         end
         f4alu_pkg::OP_MUL: begin
            s1_in.xs = sx; s1_in.xe = ea; s1_in.xm = ma;
            s1_in.ys = sb; s1_in.ye = eb; s1_in.ym = mb;
            if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = f4alu_pkg::CANON_NAN;
            end else if (inf_a || inf_b) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = {sx, 8'hFF, 23'd0};
            end else if (zero_a || zero_b) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = {sx, 31'd0};
            end
         end
         default: begin
            s1_in.xs = sx; s1_in.xe = ea; s1_in.xm = ma;
            s1_in.ys = sb; s1_in.ye = eb; s1_in.ym = mb;
            if (s1_in.err) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = 32'd0;
            end else if (nan_a || nan_b || (zero_a && zero_b) || (inf_a && inf_b)) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = f4alu_pkg::CANON_NAN;
            end else if (inf_a || zero_b) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = {sx, 8'hFF, 23'd0};
            end else if (zero_a || inf_b) begin
               s1_in.spec = 1'b1; s1_in.spec_bits = {sx, 31'd0};
            end
         end
      endcase
      s1_valid_in = adv ? req_tvalid : s1_valid_ff;
   end

   // ---------------- stage 2: align / multiply / prenormalize ----------------
   always_comb begin
      logic [7:0]  d;
      logic [5:0]  dc;
      logic [47:0] yx, mask;
      logic [4:0]  lza, lzb;
      s2_in           = '0;
      s2_in.op        = s1_ff.op;
      s2_in.spec      = s1_ff.spec;
      s2_in.spec_bits = s1_ff.spec_bits;
      s2_in.err       = s1_ff.err;
      s2_in.sgn       = s1_ff.xs;
      s2_in.ysgn      = s1_ff.ys;
      s2_in.sub       = s1_ff.xs != s1_ff.ys;
      d    = s1_ff.xe - s1_ff.ye;
      dc   = (d > 8'd47) ? 6'd63 : d[5:0];
      yx   = {1'b0, s1_ff.ym, 23'd0};
      mask = ~({48{1'b1}} << dc);
      lza  = f4alu_pkg::lzc24(s1_ff.xm);
      lzb  = f4alu_pkg::lzc24(s1_ff.ym);
      case (s1_ff.op)
         f4alu_pkg::OP_ADD, f4alu_pkg::OP_SUB: begin
            s2_in.a48 = {1'b0, s1_ff.xm, 23'd0};
            s2_in.b48 = (yx >> dc) | {47'd0, |(yx & mask)};
            s2_in.ex  = $signed({4'd0, s1_ff.xe}) + 12'sd1;
         end
         f4alu_pkg::OP_MUL: begin
            s2_in.a48 = s1_ff.xm * s1_ff.ym;
            s2_in.ex  = $signed({4'd0, s1_ff.xe}) + $signed({4'd0, s1_ff.ye}) - 12'sd126;
         end
         default: begin
            s2_in.a48 = {24'd0, s1_ff.xm << lza};
            s2_in.b48 = {24'd0, s1_ff.ym << lzb};
            s2_in.ex  = $signed({4'd0, s1_ff.xe}) - $signed({7'd0, lza})
                        - $signed({4'd0, s1_ff.ye}) + $signed({7'd0, lzb}) + 12'sd127;
         end
      endcase
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
   end

   // ---------------- stage 3: add, divider setup; then divider array ----------------
   always_comb begin
      logic [47:0] sum;
      logic        ge;
      logic [24:0] rr;
      sum = s2_ff.sub ? (s2_ff.a48 - s2_ff.b48) : (s2_ff.a48 + s2_ff.b48);
      pl_in[0]           = '0;
      pl_in[0].op        = s2_ff.op;
      pl_in[0].ex        = s2_ff.ex;
      pl_in[0].spec      = s2_ff.spec;
      pl_in[0].spec_bits = s2_ff.spec_bits;
      pl_in[0].err       = s2_ff.err;
      pl_in[0].sgn       = s2_ff.sgn;
      dv_in[0].rem       = {1'b0, s2_ff.a48[23:0]};
      dv_in[0].dvs       = s2_ff.b48[23:0];
      dv_in[0].quo       = '0;
      case (s2_ff.op)
         f4alu_pkg::OP_ADD, f4alu_pkg::OP_SUB: begin
            pl_in[0].man = sum;
            // exact cancellation gives +0 unless both effective operands were -0
            if (sum == 48'd0) pl_in[0].sgn = s2_ff.sgn & s2_ff.ysgn;
         end
         default: begin
            pl_in[0].man = s2_ff.a48;
         end
      endcase
      pv_in[0] = adv ? s2_valid_ff : pv_ff[0];

      for (int k = 0; k < NS; k++) begin
         ge              = dv_ff[k].rem >= {1'b0, dv_ff[k].dvs};
         rr              = ge ? (dv_ff[k].rem - {1'b0, dv_ff[k].dvs}) : dv_ff[k].rem;
         pl_in[k+1]      = pl_ff[k];
         dv_in[k+1].rem  = {rr[23:0], 1'b0};
         dv_in[k+1].dvs  = dv_ff[k].dvs;
         dv_in[k+1].quo  = {dv_ff[k].quo[24:0], ge};
         pv_in[k+1]      = adv ? pv_ff[k] : pv_ff[k+1];
      end
   end

   // ---------------- normalize: count, then shift ----------------
   always_comb begin
      logic [47:0]        m;
      logic [5:0]         lz;
      logic signed [11:0] en, rs;
      m = (pl_ff[NS].op == f4alu_pkg::OP_DIV)
          ? ({dv_ff[NS].quo, 22'd0} | {47'd0, dv_ff[NS].rem != 25'd0})
          : pl_ff[NS].man;
      lz = f4alu_pkg::lzc48(m);
      en = pl_ff[NS].ex - $signed({6'd0, lz});
      rs = 12'sd1 - pl_ff[NS].ex;
      n1_in        = '0;
      n1_in.pl     = pl_ff[NS];
      n1_in.pl.man = m;
      if (en >= 12'sd1) begin
         n1_in.left  = 1'b1;
         n1_in.amt   = lz;
         n1_in.pl.ex = en;
      end else if (pl_ff[NS].ex >= 12'sd1) begin
         // subnormal result reachable by a partial left shift
         n1_in.left  = 1'b1;
         n1_in.amt   = 6'(pl_ff[NS].ex - 12'sd1);
         n1_in.pl.ex = 12'sd0;
      end else begin
         n1_in.left  = 1'b0;
         n1_in.amt   = (rs > 12'sd63) ? 6'd63 : rs[5:0];
         n1_in.pl.ex = 12'sd0;
      end
      n1_valid_in = adv ? pv_ff[NS] : n1_valid_ff;
   end

   always_comb begin
      logic [47:0] mask;
      mask  = ~({48{1'b1}} << n1_ff.amt);
      n2_in = n1_ff.pl;
      n2_in.man = n1_ff.left ? (n1_ff.pl.man << n1_ff.amt)
                : ((n1_ff.pl.man >> n1_ff.amt) | {47'd0, |(n1_ff.pl.man & mask)});
      n2_valid_in = adv ? n1_valid_ff : n2_valid_ff;
   end

   // ---------------- round, pack, output register and skid ----------------
   always_comb begin
      logic [23:0]  sig;
      logic [24:0]  s25;
      logic         inc, take, push;
      logic [11:0]  ex;
      logic [31:0]  res;
      sig = n2_ff.man[47:24];
      inc = n2_ff.man[23] & ((|n2_ff.man[22:0]) | sig[0]);
      s25 = {1'b0, sig} + {24'd0, inc};
      ex  = n2_ff.ex;
      if (s25[24]) begin
         ex  = ex + 12'd1;
         sig = s25[24:1];
      end else begin
         sig = s25[23:0];
         if (ex == 12'd0 && sig[23]) ex = 12'd1;
      end
      if (n2_ff.spec) begin
         res = n2_ff.spec_bits;
      end else if (n2_ff.man == 48'd0) begin
         res = {n2_ff.sgn, 31'd0};
      end else if (ex >= 12'd255) begin
         res = {n2_ff.sgn, 8'hFF, 23'd0};
      end else begin
         res = {n2_ff.sgn, ex[7:0], sig[22:0]};
      end

      take          = out_valid_ff && rsp_tready;
      push          = adv && n2_valid_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_in       = {n2_ff.err, res};
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = {n2_ff.err, res};
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff[31:0];
   assign rsp_tuser  = out_ff[32];

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= f4alu_pkg::THRESH_RESET;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         n1_valid_ff   <= 1'b0;
         n2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) pv_ff[k] <= 1'b0;
      end else begin
         thresh_ff     <= thresh_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         n1_valid_ff   <= n1_valid_in;
         n2_valid_ff   <= n2_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int k = 0; k <= NS; k++) pv_ff[k] <= pv_in[k];
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         n1_ff <= n1_in;
         n2_ff <= n2_in;
         for (int k = 0; k <= NS; k++) begin
            pl_ff[k] <= pl_in[k];
            dv_ff[k] <= dv_in[k];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("divide error beat with nonzero result");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

   a_nan_canon: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[30:23] == 8'hFF && rsp_tdata[22:0] != 23'd0
      |-> rsp_tdata == f4alu_pkg::CANON_NAN)
      else $error("non-canonical NaN on output");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [31:0] bits;
      logic        err;
   } alu_result_type;

   class alu_scoreboard;
      logic [30:0]    thresh;
      alu_result_type pending_q[$];
      int             errors;

      function new();
         thresh = f4alu_pkg::THRESH_RESET;
         errors = 0;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      static function logic is_nan(logic [31:0] v);
         return v[30:0] > 31'h7F80_0000;
      endfunction

      // value = mant * 2^ex, rounded to nearest even into single precision
      static function logic [31:0] round_pack(logic sgn, int ex, logic [127:0] mant);
         int           p;
         int           sh;
         int           e2;
         int           be;
         logic [127:0] sig;
         logic [127:0] rem;
         logic [127:0] half;
         if (mant == 0) return {sgn, 31'd0};
         p = 0;
         for (int i = 0; i < 128; i++) if (mant[i]) p = i;
         sh = p - 23;
         if (-149 - ex > sh) sh = -149 - ex;
         if (sh > 127) sh = 127;
         if (sh <= 0) begin
            sig = mant << (-sh);
         end else begin
            sig  = mant >> sh;
            rem  = mant & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && sig[0])) sig = sig + 128'd1;
         end
         e2 = ex + sh;
         if (sig[24]) begin
            sig = sig >> 1;
            e2  = e2 + 1;
         end
         if (!sig[23]) return {sgn, 8'd0, sig[22:0]};
         be = e2 + 150;
         if (be >= 255) return {sgn, 8'hFF, 23'd0};
         return {sgn, be[7:0], sig[22:0]};
      endfunction

      function alu_result_type predict(logic [31:0] a, logic [31:0] b,
                                       f4alu_pkg::op_type op);
         alu_result_type r;
         logic           sa, sb, sr, tsign;
         logic [23:0]    ma, mb, tm;
         int             xa, xb, tx, d;
         logic [127:0]   wa, wb, wm;
         logic [63:0]    num, q, rm;
         logic           inf_a, inf_b, zero_a, zero_b;
         r.err  = 1'b0;
         sa     = a[31];
         sb     = b[31] ^ (op == f4alu_pkg::OP_SUB);
         sr     = a[31] ^ b[31];
         inf_a  = a[30:0] == 31'h7F80_0000;
         inf_b  = b[30:0] == 31'h7F80_0000;
         zero_a = a[30:0] == 0;
         zero_b = b[30:0] == 0;
         ma = (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
         mb = (b[30:23] == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
         xa = ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
         xb = ((b[30:23] == 0) ? 1 : int'(b[30:23])) - 150;
         if (op == f4alu_pkg::OP_DIV && !is_nan(b) && !is_nan({1'b0, thresh})
             && b[30:0] < thresh) begin
            r.err  = 1'b1;
            r.bits = 32'd0;
         end else if (is_nan(a) || is_nan(b)) begin
            r.bits = f4alu_pkg::CANON_NAN;
         end else begin
            case (op)
               f4alu_pkg::OP_ADD, f4alu_pkg::OP_SUB: begin
                  if (inf_a && inf_b)
                     r.bits = (sa != sb) ? f4alu_pkg::CANON_NAN : {sa, 31'h7F80_0000};
                  else if (inf_a) r.bits = {sa, 31'h7F80_0000};
                  else if (inf_b) r.bits = {sb, 31'h7F80_0000};
                  else begin
                     if (xa < xb || (xa == xb && ma < mb)) begin
                        tm = ma; ma = mb; mb = tm;
                        tx = xa; xa = xb; xb = tx;
                        tsign = sa; sa = sb; sb = tsign;
                     end
                     d  = xa - xb;
                     wa = {104'd0, ma} << 30;
                     wb = {104'd0, mb} << 30;
                     if (d >= 100) wb = {127'd0, mb != 0};
                     else wb = (wb >> d)
                               | {127'd0, (wb & ((128'd1 << d) - 128'd1)) != 0};
                     wm = (sa == sb) ? wa + wb : wa - wb;
                     if (wm == 0) r.bits = {sa & sb, 31'd0};
                     else r.bits = round_pack(sa, xa - 30, wm);
                  end
               end
               f4alu_pkg::OP_MUL: begin
                  if ((inf_a && zero_b) || (zero_a && inf_b)) r.bits = f4alu_pkg::CANON_NAN;
                  else if (inf_a || inf_b) r.bits = {sr, 31'h7F80_0000};
                  else if (zero_a || zero_b) r.bits = {sr, 31'd0};
                  else r.bits = round_pack(sr, xa + xb, 128'(ma) * 128'(mb));
               end
               default: begin
                  if ((zero_a && zero_b) || (inf_a && inf_b)) r.bits = f4alu_pkg::CANON_NAN;
                  else if (inf_a || zero_b) r.bits = {sr, 31'h7F80_0000};
                  else if (zero_a || inf_b) r.bits = {sr, 31'd0};
                  else begin
                     while (!ma[23]) begin ma = ma << 1; xa = xa - 1; end
                     while (!mb[23]) begin mb = mb << 1; xb = xb - 1; end
                     num = {14'd0, ma, 26'd0};
                     q   = num / mb;
                     rm  = num % mb;
                     wm  = {63'd0, q, rm != 0};
                     r.bits = round_pack(sr, xa - xb - 27, wm);
                  end
               end
            endcase
            if (is_nan(r.bits)) r.bits = f4alu_pkg::CANON_NAN;
         end
         return r;
      endfunction

      function void note_operation(logic [31:0] a, logic [31:0] b, f4alu_pkg::op_type op);
         pending_q.push_back(predict(a, b, op));
      endfunction

      function void check_result(logic [31:0] bits, logic err);
         alu_result_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result beat %h err %b", $time, bits, err);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (bits !== e.bits) begin
            $display("%0t: result_bits expected %h actual %h", $time, e.bits, bits);
            errors++;
         end
         if (err !== e.err) begin
            $display("%0t: divide_error expected %b actual %b", $time, e.err, err);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] operand_a, [63:32] operand_b
   logic [1:0]  req_tuser;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] result_bits
   logic        rsp_tuser;   // [0] divide_error
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   alu_scoreboard sb;
   bit            calm;

   float_four_op_alu dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_operation(req_tdata[31:0], req_tdata[63:32],
                           f4alu_pkg::op_type'(req_tuser));
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock)
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 19);

   task automatic send_op(logic [31:0] a, logic [31:0] b, f4alu_pkg::op_type op);
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // wait for every outstanding beat, then cover the pipeline depth
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_thresh(logic [30:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= f4alu_pkg::ADDR_THRESH;
      csr_pwdata  <= {1'b0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.thresh = v;
   endtask

   function automatic logic [31:0] pick_operand();
      logic [31:0] specials[8];
      specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0001, 32'hFF80_0001, 32'h7F7F_FFFF, 32'h0000_0001};
      case ($urandom_range(7))
         0, 1, 2: return $urandom;
         3:       return specials[$urandom_range(7)];
         4:       return {1'($urandom), 8'd0, 23'($urandom)};
         5:       return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
         6:       return {1'($urandom), ($urandom_range(1) ? 8'hFE : 8'h01),
                          23'($urandom)};
         default: return {1'($urandom), 8'($urandom_range(0, 30)), 23'($urandom)};
      endcase
   endfunction

   task automatic random_ops(int count);
      logic [31:0] a, b;
      for (int i = 0; i < count; i++) begin
         a = pick_operand();
         case ($urandom_range(5))
            0:       b = a ^ 32'($urandom_range(0, 255));   // heavy cancellation
            1:       b = {1'($urandom), sb.thresh + 31'($urandom_range(0, 4)) - 31'd2};
            default: b = pick_operand();
         endcase
         send_op(a, b, f4alu_pkg::op_type'($urandom_range(3)));
      end
   endtask

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [30:0] settings[7];
      sb          = new();
      calm        = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, specials, every op, threshold edges
      send_op(32'h3F80_0000, 32'h4000_0000, f4alu_pkg::OP_ADD);
      send_op(32'h3F80_0000, 32'h3F80_0000, f4alu_pkg::OP_SUB);
      send_op(32'h8000_0000, 32'h8000_0000, f4alu_pkg::OP_ADD);
      send_op(32'h7F7F_FFFF, 32'h7F7F_FFFF, f4alu_pkg::OP_ADD);
      send_op(32'h7F80_0000, 32'h7F80_0000, f4alu_pkg::OP_SUB);
      send_op(32'hFF80_0000, 32'h3F80_0000, f4alu_pkg::OP_ADD);
      send_op(32'h0000_0001, 32'h8000_0002, f4alu_pkg::OP_ADD);
      send_op(32'h0080_0000, 32'h0000_0001, f4alu_pkg::OP_SUB);
      send_op(32'h7F80_0000, 32'h0000_0000, f4alu_pkg::OP_MUL);
      send_op(32'h7F7F_FFFF, 32'h4000_0000, f4alu_pkg::OP_MUL);
      send_op(32'h0000_0001, 32'h3F00_0000, f4alu_pkg::OP_MUL);
      send_op(32'h0080_0000, 32'h3F7F_FFFF, f4alu_pkg::OP_MUL);
      send_op(32'hFFFF_FFFF, 32'h3F80_0000, f4alu_pkg::OP_MUL);
      send_op(32'h3F80_0000, 32'h0000_0000, f4alu_pkg::OP_DIV);
      send_op(32'h3F80_0000, 32'h8000_0000, f4alu_pkg::OP_DIV);
      send_op(32'h3F80_0000, 32'h3586_37BC, f4alu_pkg::OP_DIV);
      send_op(32'h3F80_0000, 32'hB586_37BD, f4alu_pkg::OP_DIV);
      send_op(32'h3F80_0000, 32'h7FC0_0000, f4alu_pkg::OP_DIV);
      send_op(32'h7F80_0000, 32'h7F80_0000, f4alu_pkg::OP_DIV);
      send_op(32'h7F7F_FFFF, 32'h3F00_0000, f4alu_pkg::OP_DIV);
      send_op(32'h0000_0001, 32'h4B00_0000, f4alu_pkg::OP_DIV);
      send_op(32'hC040_0000, 32'h4040_0000, f4alu_pkg::OP_DIV);
      drain();

      settings = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h7F80_0000, 31'h0000_0001,
                   31'($urandom), 31'h3F80_0000, f4alu_pkg::THRESH_RESET};
      foreach (settings[k]) begin
         write_thresh(settings[k]);
         calm = (k == 3);
         if (k == 0) begin
            send_op(32'h3F80_0000, 32'h0000_0000, f4alu_pkg::OP_DIV);
            send_op(32'h0000_0000, 32'h8000_0000, f4alu_pkg::OP_DIV);
         end
         random_ops(225);
         drain();
      end
      calm = 1'b0;

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/f4alu_pkg.sv
rtl/float_four_op_alu.sv
dv/tb.sv
